// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the size parser.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hsp_pkg.sv =====
// Shared constants, types and tables of the human-readable size parser.
// No dependencies; the parser modules and the testbench refer to it by scoped names.
package hsp_pkg;

    localparam int CHAR_W          = 8;
    localparam int COUNT_W         = 63;
    localparam int FRAC_DIGITS_MAX = 9;
    localparam int FRAC_W          = 30;
    localparam int FCNT_W          = 4;
    localparam int SHIFT_W         = 6;
    localparam int MAX_SHIFT       = 40;
    localparam int WIDE_W          = COUNT_W + MAX_SHIFT;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = 1;

    localparam logic [COUNT_W-1:0] VAL_MAX = {COUNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UK  = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_UM  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_UG  = 8'h47;
    localparam logic [CHAR_W-1:0] CH_UT  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_LK  = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_LM  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_LG  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LT  = 8'h74;

    localparam logic [SHIFT_W-1:0] SH_NONE = 6'd0;
    localparam logic [SHIFT_W-1:0] SH_K    = 6'd10;
    localparam logic [SHIFT_W-1:0] SH_M    = 6'd20;
    localparam logic [SHIFT_W-1:0] SH_G    = 6'd30;
    localparam logic [SHIFT_W-1:0] SH_T    = 6'd40;

    // One finished string, handed from the front to the back.
    typedef struct packed {
        logic [COUNT_W-1:0] whole;
        logic               ovf;
        logic [FRAC_W-1:0]  frac;
        logic [FCNT_W-1:0]  fcnt;
        logic [SHIFT_W-1:0] shift;
        logic               bad;
    } hsp_job_t;

    function automatic logic [SHIFT_W-1:0] suffix_shift(input logic [CHAR_W-1:0] c);
        logic [SHIFT_W-1:0] s;
        case (c)
            CH_UK, CH_LK: s = SH_K;
            CH_UM, CH_LM: s = SH_M;
            CH_UG, CH_LG: s = SH_G;
            CH_UT, CH_LT: s = SH_T;
            default:      s = SH_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        case (n)
            4'd0:    p = FRAC_W'(1);
            4'd1:    p = FRAC_W'(10);
            4'd2:    p = FRAC_W'(100);
            4'd3:    p = FRAC_W'(1000);
            4'd4:    p = FRAC_W'(10000);
            4'd5:    p = FRAC_W'(100000);
            4'd6:    p = FRAC_W'(1000000);
            4'd7:    p = FRAC_W'(10000000);
            4'd8:    p = FRAC_W'(100000000);
            4'd9:    p = FRAC_W'(1000000000);
            default: p = FRAC_W'(1);
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/human_size_parser_unit.sv =====
// Top level of the human-readable size parser: front end, string queue, back end.
// Depends on hsp_pkg, hsp_front, hsp_queue and hsp_back.

// The unit parses a size such as "1.5G" or "512k", one ASCII character per
// input beat, with tlast on the final character, and returns one result beat
// per string: the size in bytes, a malformed flag and a saturated flag. The
// body is decimal digits with at most one dot; a final K, M, G or T in either
// case multiplies by 2^10, 2^20, 2^30 or 2^40, and the fraction part is
// scaled exactly and rounded down. At most nine fraction digits are allowed.
// A malformed string gives a count of zero; a value above 2^63-1 is clamped
// to 2^63-1 with the saturated flag set. The input side takes one character
// every cycle while the string queue is not full. In the back end, a string
// with no suffix goes straight to the result step; with K, M, G or T the
// bit-serial restoring divider that scales the fraction first produces one
// quotient bit per cycle, one for each bit of the shift. A queue of two
// strings sits between the character front end and the divider; while that
// queue is full, the input holds tready low for every character, not only
// for a final one. The result sits in an output register that holds while
// the downstream side stalls. Reset is asynchronous and active low.
module human_size_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [62:0] byte_count, [63] zero fill
    output logic [1:0]  m_axis_tuser    // [0] malformed, [1] saturated
);

    hsp_pkg::hsp_job_t              push_job;
    hsp_pkg::hsp_job_t              head_job;
    logic                           push;
    logic                           q_full;
    logic                           head_valid;
    logic                           pop;
    logic [hsp_pkg::COUNT_W-1:0]    byte_count;
    logic                           malformed;
    logic                           saturated;

    // Character front end: accumulates the whole part, fraction and flags.
    hsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .last_char (s_axis_tlast),
        .push      (push),
        .job       (push_job),
        .q_full    (q_full)
    );

    // Finished strings wait here while the back end is busy.
    hsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Scaling, fraction division, saturation and the result register.
    hsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .byte_count (byte_count),
        .malformed  (malformed),
        .saturated  (saturated)
    );

    assign m_axis_tdata = {1'b0, byte_count};
    assign m_axis_tuser = {saturated, malformed};

endmodule

// ===== hw/rtl/hsp_front.sv =====
// Front end of the size parser: takes characters and builds the accumulators.
// Depends on hsp_pkg; pushes one hsp_job_t per string into hsp_queue.
module hsp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hsp_pkg::CHAR_W-1:0] char_code,
    input  logic                       last_char,
    output logic                       push,
    output hsp_pkg::hsp_job_t          job,
    input  logic                       q_full
);

    logic [hsp_pkg::COUNT_W-1:0] whole_reg, whole_next;
    logic                        ovf_reg, ovf_next;
    logic [hsp_pkg::FRAC_W-1:0]  frac_reg, frac_next;
    logic [hsp_pkg::FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic                        dot_reg, dot_next;
    logic                        bad_reg, bad_next;
    logic                        body_reg, body_next;

    logic [hsp_pkg::SHIFT_W-1:0]   shift;
    logic                          is_suffix;
    logic                          is_dot;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [hsp_pkg::COUNT_W+3:0]   whole_x10;
    logic [hsp_pkg::FRAC_W+3:0]    frac_x10;
    logic                          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign shift     = hsp_pkg::suffix_shift(char_code);
    assign is_suffix = last_char && (shift != hsp_pkg::SH_NONE);
    assign is_dot    = (char_code == hsp_pkg::CH_DOT);
    assign is_digit  = (char_code >= hsp_pkg::CH_0) && (char_code <= hsp_pkg::CH_9);
    assign digit     = 4'(char_code - hsp_pkg::CH_0);

    assign whole_x10 = ({4'b0, whole_reg} << 3) + ({4'b0, whole_reg} << 1)
                     + (hsp_pkg::COUNT_W + 4)'(digit);
    assign frac_x10  = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1)
                     + (hsp_pkg::FRAC_W + 4)'(digit);

    always_comb
    begin
        whole_next = whole_reg;
        ovf_next   = ovf_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        dot_next   = dot_reg;
        bad_next   = bad_reg;
        body_next  = body_reg;
        if (is_suffix)
        begin
            // A scale letter with nothing in front of it is not a size.
            if (!body_reg)
            begin
                bad_next = 1'b1;
            end
        end
        else
        begin
            body_next = 1'b1;
            if (!bad_reg)
            begin
                if (is_dot)
                begin
                    bad_next = dot_reg;
                    dot_next = 1'b1;
                end
                else if (!is_digit)
                begin
                    bad_next = 1'b1;
                end
                else if (!dot_reg)
                begin
                    if (ovf_reg || (whole_x10[hsp_pkg::COUNT_W+3:hsp_pkg::COUNT_W] != 4'd0))
                    begin
                        ovf_next   = 1'b1;
                        whole_next = hsp_pkg::VAL_MAX;
                    end
                    else
                    begin
                        whole_next = whole_x10[hsp_pkg::COUNT_W-1:0];
                    end
                end
                else if (fcnt_reg >= hsp_pkg::FCNT_W'(hsp_pkg::FRAC_DIGITS_MAX))
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    frac_next = frac_x10[hsp_pkg::FRAC_W-1:0];
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end
        end
    end

    assign push      = accept && last_char;
    assign job.whole = whole_next;
    assign job.ovf   = ovf_next;
    assign job.frac  = frac_next;
    assign job.fcnt  = fcnt_next;
    assign job.shift = is_suffix ? shift : hsp_pkg::SH_NONE;
    assign job.bad   = bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= '0;
            ovf_reg   <= 1'b0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            dot_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            body_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                whole_reg <= '0;
                ovf_reg   <= 1'b0;
                frac_reg  <= '0;
                fcnt_reg  <= '0;
                dot_reg   <= 1'b0;
                bad_reg   <= 1'b0;
                body_reg  <= 1'b0;
            end
            else
            begin
                whole_reg <= whole_next;
                ovf_reg   <= ovf_next;
                frac_reg  <= frac_next;
                fcnt_reg  <= fcnt_next;
                dot_reg   <= dot_next;
                bad_reg   <= bad_next;
                body_reg  <= body_next;
            end
        end
    end

endmodule

// ===== hw/rtl/hsp_queue.sv =====
// Two-entry queue of finished strings between the front and the back.
// Depends on hsp_pkg for the entry type and depth.
module hsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hsp_pkg::hsp_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output hsp_pkg::hsp_job_t head_job
);

    hsp_pkg::hsp_job_t             mem [hsp_pkg::QDEPTH];
    logic [hsp_pkg::QPTR_W-1:0]    wptr_reg;
    logic [hsp_pkg::QPTR_W-1:0]    rptr_reg;
    logic [hsp_pkg::QPTR_W:0]      count_reg;

    assign full       = (count_reg == (hsp_pkg::QPTR_W + 1)'(hsp_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hsp_back.sv =====
// Back end of the size parser: scales one string and divides the fraction.
// Depends on hsp_pkg; takes jobs from hsp_queue and drives the result register.
module hsp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  hsp_pkg::hsp_job_t           head_job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hsp_pkg::COUNT_W-1:0] byte_count,
    output logic                        malformed,
    output logic                        saturated
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                         state_reg;
    hsp_pkg::hsp_job_t              job_reg;
    logic [hsp_pkg::FRAC_W-1:0]     rem_reg;
    logic [hsp_pkg::FRAC_W-1:0]     den_reg;
    logic [hsp_pkg::MAX_SHIFT-1:0]  quo_reg;
    logic [hsp_pkg::SHIFT_W-1:0]    step_reg;
    logic                           out_valid_reg;
    logic [hsp_pkg::COUNT_W-1:0]    byte_count_reg;
    logic                           malformed_reg;
    logic                           saturated_reg;

    logic [hsp_pkg::FRAC_W:0]       rem2;
    logic                           ge;
    logic [hsp_pkg::WIDE_W-1:0]     wide;
    logic                           too_big;
    logic [hsp_pkg::COUNT_W:0]      total;
    logic                           sat;
    logic                           load_out;

    // One restoring division step: one quotient bit per cycle.
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    // Whole part scaled by the suffix; anything above bit 62 means overflow.
    assign wide    = {{hsp_pkg::MAX_SHIFT{1'b0}}, job_reg.whole} << job_reg.shift;
    assign too_big = (wide[hsp_pkg::WIDE_W-1:hsp_pkg::COUNT_W] != '0);
    assign total   = {1'b0, wide[hsp_pkg::COUNT_W-1:0]}
                   + (hsp_pkg::COUNT_W + 1)'(quo_reg);
    assign sat     = job_reg.ovf || too_big || total[hsp_pkg::COUNT_W];

    assign pop      = (state_reg == ST_IDLE) && head_valid;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign byte_count = byte_count_reg;
    assign malformed  = malformed_reg;
    assign saturated  = saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            job_reg        <= '0;
            rem_reg        <= '0;
            den_reg        <= '0;
            quo_reg        <= '0;
            step_reg       <= '0;
            byte_count_reg <= '0;
            malformed_reg  <= 1'b0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            // A beat taken this cycle is replaced below when the next one is ready.
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        job_reg  <= head_job;
                        rem_reg  <= head_job.frac;
                        den_reg  <= hsp_pkg::pow10(head_job.fcnt);
                        quo_reg  <= '0;
                        step_reg <= head_job.shift;
                        state_reg <= (head_job.shift == hsp_pkg::SH_NONE) ? ST_FIN : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= ge ? hsp_pkg::FRAC_W'(rem2 - {1'b0, den_reg})
                                   : rem2[hsp_pkg::FRAC_W-1:0];
                    quo_reg  <= {quo_reg[hsp_pkg::MAX_SHIFT-2:0], ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == hsp_pkg::SHIFT_W'(1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        malformed_reg <= job_reg.bad;
                        if (job_reg.bad)
                        begin
                            byte_count_reg <= '0;
                            saturated_reg  <= 1'b0;
                        end
                        else
                        begin
                            byte_count_reg <= sat ? hsp_pkg::VAL_MAX
                                                  : total[hsp_pkg::COUNT_W-1:0];
                            saturated_reg  <= sat;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/hsp_checker.sv =====
// Port-level checks of the size parser, bound to human_size_parser_unit.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic out_stall;

    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result beat stays valid and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A malformed string reports zero bytes and never saturation.
    `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        (m_axis_tdata == 64'd0) && !m_axis_tuser[1])

    // A saturated result is exactly the largest count.
    `ASSERT_IMPLIES(a_sat_max, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        &m_axis_tdata[62:0])

    // The fill bit above the byte count is always clear.
    `ASSERT_IMPLIES(a_fill_zero, clk, rst_n, m_axis_tvalid, !m_axis_tdata[63])

endmodule

bind human_size_parser_unit hsp_checker u_hsp_checker (.*);

// ===== verif/size_parse_checker.sv =====
// Scoreboard for the human-readable size parser. It watches the character and result
// stream channels, computes each parsed size from the accepted characters and compares it.
// Depends on hsp_pkg for the character codes, the fraction digit limit and the clamp value.
module size_parse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_code
    input  logic        s_axis_tlast,    // last_char
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,    // [62:0] byte_count, [63] zero fill
    input  logic [1:0]  m_axis_tuser,    // [0] malformed, [1] saturated
    output int          fail_count,
    output int          sizes_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] CLAMP = {1'b0, hsp_pkg::VAL_MAX};

    typedef struct packed {
        logic [62:0] byte_count;
        logic        malformed;
        logic        saturated;
    } parsed_size_t;

    parsed_size_t sizes_due[$];

    // Parse state of the string in flight.
    logic [63:0] int_part;
    logic [63:0] frac_value;
    int unsigned frac_digits;
    bit          saw_dot;
    bit          saw_bad;
    bit          saw_body;
    bit          int_overflow;

    function automatic void clear_string();
        int_part     = '0;
        frac_value   = '0;
        frac_digits  = 0;
        saw_dot      = 1'b0;
        saw_bad      = 1'b0;
        saw_body     = 1'b0;
        int_overflow = 1'b0;
    endfunction

    function automatic void take_body_char(input logic [7:0] c);
        logic [63:0] d;
        saw_body = 1'b1;
        if (saw_bad)
            return;
        if (c == hsp_pkg::CH_DOT)
        begin
            if (saw_dot)
                saw_bad = 1'b1;
            saw_dot = 1'b1;
            return;
        end
        if (c < hsp_pkg::CH_0 || c > hsp_pkg::CH_9)
        begin
            saw_bad = 1'b1;
            return;
        end
        d = {56'd0, c - hsp_pkg::CH_0};
        if (!saw_dot)
        begin
            // The integer part sticks at the clamp value once it runs over.
            if (int_overflow || int_part > (CLAMP - d) / 64'd10)
            begin
                int_overflow = 1'b1;
                int_part     = CLAMP;
            end
            else
            begin
                int_part = int_part * 64'd10 + d;
            end
        end
        else if (frac_digits >= hsp_pkg::FRAC_DIGITS_MAX)
        begin
            saw_bad = 1'b1;
        end
        else
        begin
            frac_value  = frac_value * 64'd10 + d;
            frac_digits = frac_digits + 1;
        end
    endfunction

    function automatic parsed_size_t finish_string(input logic [7:0] c);
        int unsigned  shift;
        int unsigned  i;
        logic [63:0]  value;
        logic [63:0]  den;
        logic [63:0]  rem;
        logic [63:0]  quo;
        logic [63:0]  scaled_int;
        parsed_size_t res;
        case (c)
            hsp_pkg::CH_UK, hsp_pkg::CH_LK: shift = 10;
            hsp_pkg::CH_UM, hsp_pkg::CH_LM: shift = 20;
            hsp_pkg::CH_UG, hsp_pkg::CH_LG: shift = 30;
            hsp_pkg::CH_UT, hsp_pkg::CH_LT: shift = 40;
            default:                        shift = 0;
        endcase
        if (shift != 0)
        begin
            if (!saw_body)
                saw_bad = 1'b1;
        end
        else
        begin
            take_body_char(c);
        end
        value         = '0;
        res.saturated = 1'b0;
        if (!saw_bad)
        begin
            if (int_overflow || int_part > (CLAMP >> shift))
            begin
                res.saturated = 1'b1;
                value         = CLAMP;
            end
            else
            begin
                den = 64'd1;
                for (i = 0; i < frac_digits; i++)
                    den = den * 64'd10;
                // Fraction times 2^shift over 10^digits, one quotient bit per step.
                rem = frac_value;
                quo = '0;
                for (i = 0; i < shift; i++)
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= den)
                    begin
                        rem    = rem - den;
                        quo[0] = 1'b1;
                    end
                end
                scaled_int = int_part << shift;
                if (quo > CLAMP - scaled_int)
                begin
                    res.saturated = 1'b1;
                    value         = CLAMP;
                end
                else
                begin
                    value = scaled_int + quo;
                end
            end
        end
        res.byte_count = value[62:0];
        res.malformed  = saw_bad;
        clear_string();
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parsed_size_t want;
        int           errs;
        errs = 0;
        if (!rst_n)
        begin
            clear_string();
            sizes_due.delete();
            fail_count      <= 0;
            sizes_due_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tlast)
                    sizes_due.push_back(finish_string(s_axis_tdata));
                else
                    take_body_char(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sizes_due.size() == 0)
                begin
                    $error("result beat with no size pending: byte_count %0d",
                           m_axis_tdata[62:0]);
                    errs++;
                end
                else
                begin
                    want = sizes_due.pop_front();
                    if (m_axis_tdata[62:0] !== want.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, m_axis_tdata[62:0]);
                        errs++;
                    end
                    if (m_axis_tuser[0] !== want.malformed)
                    begin
                        $error("malformed: expected %0b, got %0b",
                               want.malformed, m_axis_tuser[0]);
                        errs++;
                    end
                    if (m_axis_tuser[1] !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, m_axis_tuser[1]);
                        errs++;
                    end
                end
            end
            sizes_due_count <= sizes_due.size();
            fail_count      <= fail_count + errs;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the size parser testbench: clock, reset, character stimulus and the verdict.
// Depends on hsp_pkg, human_size_parser_unit and size_parse_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // A slow correct run is well under a fifth of this: every character a
    // final T, with the full divide in the back end, plus long receiver stalls.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CHARS = 1150;
    localparam int TAIL_CYCLES  = 64;

    localparam logic [63:0] CLAMP = {1'b0, hsp_pkg::VAL_MAX};

    typedef logic [7:0] char_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;     // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;             // [62:0] byte_count, [63] zero fill
    logic [1:0]  m_axis_tuser;             // [0] malformed, [1] saturated

    int fail_count;
    int sizes_due_count;
    int cycle_count = 0;
    int chars_sent  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    human_size_parser_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    size_parse_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .sizes_due_count (sizes_due_count)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side. Normally tready is redrawn every cycle from the current idle
    // percentage. When the stimulus raises hold_req, tready stays low for a
    // fixed stretch counted here, so that the queue in front of the divider
    // fills up and the character input has to stall.
    initial
    begin : result_sink
        int k;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Drives one string, a character per beat, tlast on the final one. Gaps are
    // inserted before any beat, so they also fall inside strings. tvalid is
    // left high on return, so back-to-back strings follow with no gap between them.
    task automatic send_text(input char_t s[$]);
        int i;
        for (i = 0; i < s.size(); i++)
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= s[i];
            s_axis_tlast  <= (i == s.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            @(negedge clk);
            chars_sent++;
        end
    endtask

    task automatic send_word(input string w);
        char_t s[$];
        int    i;
        for (i = 0; i < w.len(); i++)
            s.push_back(w[i]);
        send_text(s);
    endtask

    // The sender goes quiet until every size it caused has come back. It
    // always waits on the clock before checking, so tvalid drops before the next beat.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sizes_due_count != 0);
    endtask

    // Builds one random string. Most are well formed with random content, some
    // sit right at the clamp threshold of each suffix, and the rest are broken
    // strings and raw byte noise.
    function automatic void build_random(ref char_t s[$]);
        char_t       letters[8] = '{hsp_pkg::CH_UK, hsp_pkg::CH_LK, hsp_pkg::CH_UM,
                                    hsp_pkg::CH_LM, hsp_pkg::CH_UG, hsp_pkg::CH_LG,
                                    hsp_pkg::CH_UT, hsp_pkg::CH_LT};
        int          kind;
        int          n;
        int          pos;
        int          sh;
        logic [63:0] v;
        s.delete();
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            // Mostly short integer parts, now and then long enough to overflow.
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(7, 0);
            repeat (n)
                s.push_back(hsp_pkg::CH_0 + char_t'($urandom_range(9)));
            if ($urandom_range(1))
            begin
                s.push_back(hsp_pkg::CH_DOT);
                // One in eight gets one fraction digit too many.
                n = ($urandom_range(7) == 0) ? hsp_pkg::FRAC_DIGITS_MAX + 1
                                             : $urandom_range(hsp_pkg::FRAC_DIGITS_MAX);
                repeat (n)
                    s.push_back(hsp_pkg::CH_0 + char_t'($urandom_range(9)));
            end
            if ($urandom_range(3) != 0)
                s.push_back(letters[$urandom_range(7)]);
            if (s.size() == 0)
                s.push_back(hsp_pkg::CH_0 + char_t'($urandom_range(9)));
        end
        else if (kind < 75)
        begin
            // Integer part within two of the largest value the suffix allows.
            sh  = $urandom_range(4);
            v   = (CLAMP >> (10 * sh)) + 64'($urandom_range(4)) - 64'd2;
            pos = s.size();
            do
            begin
                s.insert(pos, hsp_pkg::CH_0 + char_t'(v % 64'd10));
                v = v / 64'd10;
            end
            while (v != 0);
            if ($urandom_range(1))
            begin
                s.push_back(hsp_pkg::CH_DOT);
                repeat ($urandom_range(hsp_pkg::FRAC_DIGITS_MAX))
                    s.push_back(hsp_pkg::CH_0 + char_t'($urandom_range(9)));
            end
            if (sh != 0)
                s.push_back(letters[2 * (sh - 1) + $urandom_range(1)]);
        end
        else if (kind < 90)
        begin
            // Broken strings: digits, dots, suffix letters and raw bytes in any order.
            repeat ($urandom_range(8, 1))
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: s.push_back(hsp_pkg::CH_0 + char_t'($urandom_range(9)));
                    4, 5:       s.push_back(hsp_pkg::CH_DOT);
                    6, 7:       s.push_back(letters[$urandom_range(7)]);
                    default:    s.push_back(char_t'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(3, 1))
                s.push_back(char_t'($urandom_range(255)));
        end
    endfunction

    initial
    begin : stimulus
        char_t text[$];
        int    phase;
        int    target;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings, no idling: a lone zero, a lone dot (value 0), a
        // suffix with no body, a second dot, a suffix letter that is not last,
        // the two byte extremes as whole strings, a scaled total over the
        // clamp, one fraction digit too many, and ordinary scaled fractions.
        send_word("0");
        send_word(".");
        send_word("K");
        send_word("..");
        send_word("k1");
        text = '{8'hFF};
        send_text(text);
        text = '{8'h00};
        send_text(text);
        send_word("8388608T");
        send_word(".1234567890");
        send_word("1.5m");
        send_word(".5T");
        wait_for_results();

        // Back-pressure: the receiver holds off while short strings keep
        // coming, so the string queue fills and the character input stalls.
        hold_req = 1'b1;
        repeat (8)
            send_word("1g");
        while (hold_req)
            @(negedge clk);
        wait_for_results();

        // Random strings in three phases, the last with no idling, draining after each one.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 85;
                end
                1:
                begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            target = chars_sent + RANDOM_CHARS / 3;
            while (chars_sent < target)
            begin
                build_random(text);
                send_text(text);
            end
            wait_for_results();
        end

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hsp_pkg.sv
hw/rtl/hsp_front.sv
hw/rtl/hsp_queue.sv
hw/rtl/hsp_back.sv
hw/rtl/human_size_parser_unit.sv
hw/rtl/hsp_checker.sv
verif/size_parse_checker.sv
verif/tb_top.sv
